FILE: src/windowed_clock_regression_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the windowed clock regression
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_CLOCK_REGRESSION_DEFINES_SVH
`define WINDOWED_CLOCK_REGRESSION_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define WCR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("windowed_clock_regression: implication violated");

// antecedent implies consequent in the next cycle
`define WCR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("windowed_clock_regression: next-cycle implication violated");

// condition never holds
`define WCR_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("windowed_clock_regression: forbidden condition seen");

`endif

FILE: src/wcr_pkg.sv
// ----------------------------------------------------------------------------
// wcr_pkg
// Field widths, command codes, controller/datapath structs and saturation.
// ----------------------------------------------------------------------------
package wcr_pkg;

	localparam int EPOCH_W    = 32;
	localparam int TICK_W     = 16;
	localparam int DEV_W      = EPOCH_W + TICK_W;
	localparam int LOC_W      = 63;
	localparam int FIX_W      = 64;
	localparam int FRAC_W     = 32;
	localparam int DEPTH_DEF  = 16;
	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 192;

	// multiplier operand sources
	typedef logic [3:0] sel_t;
	localparam sel_t SEL_OD   = 4'd0;
	localparam sel_t SEL_OL   = 4'd1;
	localparam sel_t SEL_DEV  = 4'd2;
	localparam sel_t SEL_LOC  = 4'd3;
	localparam sel_t SEL_N    = 4'd4;
	localparam sel_t SEL_SD   = 4'd5;
	localparam sel_t SEL_SL   = 4'd6;
	localparam sel_t SEL_SDD  = 4'd7;
	localparam sel_t SEL_SDL  = 4'd8;
	localparam sel_t SEL_T1P1 = 4'd9;
	localparam sel_t SEL_GM   = 4'd10;

	// what to do with a finished product
	typedef logic [3:0] post_t;
	localparam post_t POST_NONE     = 4'd0;
	localparam post_t POST_SDD_SUB  = 4'd1;
	localparam post_t POST_SDL_SUB  = 4'd2;
	localparam post_t POST_SDD_ADD  = 4'd3;
	localparam post_t POST_SDL_ADD  = 4'd4;
	localparam post_t POST_T1       = 4'd5;
	localparam post_t POST_DEN_DIFF = 4'd6;
	localparam post_t POST_NUM_DIFF = 4'd7;
	localparam post_t POST_NUM_DSH  = 4'd8;
	localparam post_t POST_DEN_P    = 4'd9;
	localparam post_t POST_NUM_PSH  = 4'd10;
	localparam post_t POST_CONV_SUM = 4'd11;

	typedef struct packed {
		logic  ld_item;
		logic  ram_rd;
		logic  ld_old;
		logic  sums;
		logic  mul_go;
		sel_t  a_sel;
		sel_t  b_sel;
		post_t post;
		logic  div_go;
		logic  ld_gain;
		logic  ld_off;
		logic  num_sl;
		logic  conv_out;
		logic  out_ld;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic dz;
	} sts_t;

	// sign and magnitude to saturated two's complement
	function automatic logic [FIX_W-1:0] sat64(input logic [FIX_W:0] q, input logic ovf,
		input logic neg);
		logic [FIX_W-1:0] r;
		if (neg) begin
			if (ovf || (q >= {2'b01, {(FIX_W-1){1'b0}}}))
				r = {1'b1, {(FIX_W-1){1'b0}}};
			else
				r = -q[FIX_W-1:0];
		end else begin
			if (ovf || (q > {2'b00, {(FIX_W-1){1'b1}}}))
				r = {1'b0, {(FIX_W-1){1'b1}}};
			else
				r = q[FIX_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: src/wcr_ram.sv
// ----------------------------------------------------------------------------
// wcr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wcr_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule

FILE: src/wcr_mul.sv
// ----------------------------------------------------------------------------
// wcr_mul
// Iterative multiplier: one 32x32 partial product a cycle into a wide sum.
// ----------------------------------------------------------------------------
module wcr_mul #(
	parameter int OP_W = 120,
	parameter int P_W  = 177
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  logic [OP_W-1:0] a,
	input  logic [OP_W-1:0] b,
	output logic [P_W-1:0]  p,
	output logic            done
);
	import wcr_pkg::*;

	localparam int DIG_W = 32;
	localparam int ND    = (OP_W + DIG_W - 1) / DIG_W;
	localparam int PAD_W = ND * DIG_W;
	localparam int ACC_W = 2 * PAD_W;
	localparam int CW    = $clog2(ND);

	logic [PAD_W-1:0]   a_q, b_q;
	logic [ACC_W-1:0]   acc_q;
	logic [CW-1:0]      i_q, j_q;
	logic               busy_q;
	logic [2*DIG_W-1:0] prod_s1;
	logic [CW:0]        sh_s1;
	logic               pv_s1, last_s1;
	logic               done_q;
	logic               last_dig;

	assign last_dig = (i_q == CW'(ND-1)) && (j_q == CW'(ND-1));

	// walk the digit pairs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pv_s1   <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			done_q <= pv_s1 && last_s1;
			pv_s1  <= busy_q;
			last_s1 <= busy_q && last_dig;
			if (go) begin
				busy_q <= 1'b1;
				i_q    <= '0;
				j_q    <= '0;
			end else if (busy_q) begin
				if (j_q == CW'(ND-1)) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
				if (last_dig)
					busy_q <= 1'b0;
			end
		end
	end

	// operands, partial product and accumulation
	always_ff @(posedge clk) begin
		if (go) begin
			a_q   <= PAD_W'(a);
			b_q   <= PAD_W'(b);
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q + (ACC_W'(prod_s1) << {sh_s1, 5'b0});
		end
		prod_s1 <= a_q[i_q*DIG_W +: DIG_W] * b_q[j_q*DIG_W +: DIG_W];
		sh_s1   <= (CW+1)'(i_q) + (CW+1)'(j_q);
	end

	assign p    = acc_q[P_W-1:0];
	assign done = done_q;
endmodule

FILE: src/wcr_div.sv
// ----------------------------------------------------------------------------
// wcr_div
// Restoring divider: 64 quotient bits, one a cycle, round to nearest.
// ----------------------------------------------------------------------------
module wcr_div #(
	parameter int NUM_W = 177,
	parameter int DEN_W = 114
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [wcr_pkg::FIX_W:0] quo,
	output logic             ovf
);
	import wcr_pkg::*;

	localparam int CNT_W = $clog2(FIX_W);
	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_RUN  = 2'd1;
	localparam logic [1:0] D_RND  = 2'd2;

	logic [1:0]       st_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [FIX_W-1:0] low_q, quo_q;
	logic [FIX_W:0]   res_q;
	logic             ovf_q, done_q;
	logic [DEN_W-1:0] hi_ext;
	logic [DEN_W:0]   trial, diff, twice;
	logic             ge, rup;

	// quotient of the top part decides overflow; the rest is 64 steps
	assign hi_ext = DEN_W'(num[NUM_W-1:FIX_W]);
	assign trial  = {rem_q, low_q[FIX_W-1]};
	assign diff   = trial - {1'b0, den};
	assign ge     = trial >= {1'b0, den};
	assign twice  = {rem_q, 1'b0};
	assign rup    = twice >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= D_IDLE;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				D_IDLE: begin
					if (go) begin
						cnt_q <= '0;
						st_q  <= D_RUN;
					end
				end
				D_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(FIX_W-1))
						st_q <= D_RND;
				end
				D_RND: begin
					done_q <= 1'b1;
					st_q   <= D_IDLE;
				end
				default: st_q <= D_IDLE;
			endcase
		end
	end

	// remainder, quotient and rounded result
	always_ff @(posedge clk) begin
		if (st_q == D_IDLE && go) begin
			ovf_q <= hi_ext >= den;
			rem_q <= hi_ext;
			low_q <= num[FIX_W-1:0];
		end else if (st_q == D_RUN) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[FIX_W-2:0], ge};
			low_q <= {low_q[FIX_W-2:0], 1'b0};
		end else if (st_q == D_RND) begin
			res_q <= {1'b0, quo_q} + (FIX_W+1)'(rup);
		end
	end

	assign done = done_q;
	assign quo  = res_q;
	assign ovf  = ovf_q;
endmodule

FILE: src/wcr_datapath.sv
// ----------------------------------------------------------------------------
// wcr_datapath
// Ring, running sums, fit registers, shared multiplier and divider.
// ----------------------------------------------------------------------------
module wcr_datapath #(
	parameter int WINDOW_DEPTH = wcr_pkg::DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wcr_pkg::cmd_t                   cmd,
	output wcr_pkg::sts_t                   sts,
	input  logic [wcr_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic                            s_tuser,
	output logic [wcr_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                            m_tuser
);
	import wcr_pkg::*;

	localparam int NB    = $clog2(WINDOW_DEPTH + 1);
	localparam int AW    = $clog2(WINDOW_DEPTH);
	localparam int SD_W  = DEV_W + NB;
	localparam int SL_W  = LOC_W + NB;
	localparam int SDD_W = 2 * DEV_W + NB;
	localparam int SDL_W = DEV_W + LOC_W + NB;
	localparam int DEN_W = 2 * DEV_W + 2 * NB;
	localparam int P_W   = SDD_W + SL_W;
	localparam int OP_W  = SDL_W;
	localparam int RAM_W = DEV_W + LOC_W;

	// item and ring
	logic                    kind_q;
	logic [DEV_W-1:0]        dev_q, od_q;
	logic [LOC_W-1:0]        loc_q, ol_q;
	logic [AW-1:0]           slot_q, nslot;
	logic [WINDOW_DEPTH-1:0] valid_q;
	logic                    rvalid_q;
	logic [RAM_W-1:0]        rdata;

	// sums and fit
	logic [SD_W-1:0]  sd_q;
	logic [SL_W-1:0]  sl_q;
	logic [SDD_W-1:0] sdd_q;
	logic [SDL_W-1:0] sdl_q;
	logic [FIX_W-1:0] gain_q, off_q, conv_q;
	logic [P_W-1:0]   t1_q, num_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q, dz_q;

	// results
	logic             upd_o;
	logic [FIX_W-1:0] gain_o, off_o, conv_o;

	// units
	logic [OP_W-1:0]  op_a, op_b;
	logic [P_W-1:0]   prod;
	logic             mul_done, div_done, div_ovf;
	logic [FIX_W:0]   div_q;

	logic [FIX_W-1:0] gm, om;
	logic [DEN_W-1:0] dden;
	logic             lt_t1;
	logic [P_W-1:0]   mag, p2, csum;
	logic             cneg, c_lt;
	logic [FIX_W:0]   cq;
	logic             covf;

	assign nslot = (slot_q == AW'(WINDOW_DEPTH-1)) ? '0 : slot_q + 1'b1;
	assign gm    = gain_q[FIX_W-1] ? -gain_q : gain_q;
	assign om    = off_q[FIX_W-1] ? -off_q : off_q;

	wcr_ram #(.W(RAM_W), .DEPTH(WINDOW_DEPTH)) u_ring (
		.clk   (clk),
		.we    (cmd.sums),
		.waddr (nslot),
		.wdata ({loc_q, dev_q}),
		.re    (cmd.ram_rd),
		.raddr (nslot),
		.rdata (rdata)
	);

	// pick multiplier operands
	always_comb begin
		unique case (cmd.a_sel)
			SEL_OD:   op_a = OP_W'(od_q);
			SEL_OL:   op_a = OP_W'(ol_q);
			SEL_DEV:  op_a = OP_W'(dev_q);
			SEL_LOC:  op_a = OP_W'(loc_q);
			SEL_N:    op_a = OP_W'(WINDOW_DEPTH);
			SEL_SD:   op_a = OP_W'(sd_q);
			SEL_SL:   op_a = OP_W'(sl_q);
			SEL_SDD:  op_a = OP_W'(sdd_q);
			SEL_SDL:  op_a = OP_W'(sdl_q);
			SEL_T1P1: op_a = t1_q[OP_W-1:0] + 1'b1;
			SEL_GM:   op_a = OP_W'(gm);
			default:  op_a = '0;
		endcase
		unique case (cmd.b_sel)
			SEL_OD:   op_b = OP_W'(od_q);
			SEL_OL:   op_b = OP_W'(ol_q);
			SEL_DEV:  op_b = OP_W'(dev_q);
			SEL_LOC:  op_b = OP_W'(loc_q);
			SEL_N:    op_b = OP_W'(WINDOW_DEPTH);
			SEL_SD:   op_b = OP_W'(sd_q);
			SEL_SL:   op_b = OP_W'(sl_q);
			SEL_SDD:  op_b = OP_W'(sdd_q);
			SEL_SDL:  op_b = OP_W'(sdl_q);
			SEL_T1P1: op_b = t1_q[OP_W-1:0] + 1'b1;
			SEL_GM:   op_b = OP_W'(gm);
			default:  op_b = '0;
		endcase
	end

	wcr_mul #(.OP_W(OP_W), .P_W(P_W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.mul_go),
		.a      (op_a),
		.b      (op_b),
		.p      (prod),
		.done   (mul_done)
	);

	wcr_div #(.NUM_W(P_W), .DEN_W(DEN_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.div_go),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_q),
		.ovf    (div_ovf)
	);

	// differences for the post-product steps
	assign dden  = t1_q[DEN_W-1:0] - prod[DEN_W-1:0];
	assign lt_t1 = t1_q < prod;
	assign mag   = lt_t1 ? prod - t1_q : t1_q - prod;

	// signed sum for conversion: dev*|gain| against |offset|<<32
	always_comb begin
		p2 = '0;
		p2[FRAC_W +: FIX_W] = om;
		c_lt = prod < p2;
		if (gain_q[FIX_W-1] == off_q[FIX_W-1]) begin
			csum = prod + p2;
			cneg = gain_q[FIX_W-1];
		end else if (c_lt) begin
			csum = p2 - prod;
			cneg = off_q[FIX_W-1];
		end else begin
			csum = prod - p2;
			cneg = gain_q[FIX_W-1];
		end
	end

	// round the converted sum by 2^32
	assign covf = |num_q[P_W-1:FRAC_W+FIX_W];
	assign cq   = {1'b0, num_q[FRAC_W +: FIX_W]} + (FIX_W+1)'(num_q[FRAC_W-1]);

	// control state of the ring and the fit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			valid_q <= '0;
			sd_q    <= SD_W'(WINDOW_DEPTH);
			sl_q    <= SL_W'(WINDOW_DEPTH);
			sdd_q   <= SDD_W'(WINDOW_DEPTH);
			sdl_q   <= SDL_W'(WINDOW_DEPTH);
			gain_q  <= '0;
			off_q   <= '0;
		end else begin
			if (cmd.sums) begin
				slot_q         <= nslot;
				valid_q[nslot] <= 1'b1;
				sd_q <= sd_q - SD_W'(od_q) + SD_W'(dev_q);
				sl_q <= sl_q - SL_W'(ol_q) + SL_W'(loc_q);
			end
			if (mul_done) begin
				unique case (cmd.post)
					POST_SDD_SUB: sdd_q <= sdd_q - prod[SDD_W-1:0];
					POST_SDD_ADD: sdd_q <= sdd_q + prod[SDD_W-1:0];
					POST_SDL_SUB: sdl_q <= sdl_q - prod[SDL_W-1:0];
					POST_SDL_ADD: sdl_q <= sdl_q + prod[SDL_W-1:0];
					default: ;
				endcase
			end
			if (cmd.ld_gain)
				gain_q <= sat64(div_q, div_ovf, neg_q);
			if (cmd.ld_off)
				off_q <= sat64(div_q, div_ovf, neg_q);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			kind_q <= s_tuser;
			dev_q  <= {s_tdata[EPOCH_W-1:0], s_tdata[EPOCH_W +: TICK_W]};
			loc_q  <= s_tdata[DEV_W +: LOC_W];
		end
		if (cmd.ram_rd)
			rvalid_q <= valid_q[nslot];
		if (cmd.ld_old) begin
			od_q <= rvalid_q ? rdata[DEV_W-1:0] : DEV_W'(1);
			ol_q <= rvalid_q ? rdata[DEV_W +: LOC_W] : LOC_W'(1);
		end
		if (mul_done) begin
			unique case (cmd.post)
				POST_T1:       t1_q <= prod;
				POST_DEN_DIFF: begin
					den_q <= dden;
					dz_q  <= (dden == '0);
				end
				POST_NUM_DIFF: begin
					num_q <= mag;
					neg_q <= lt_t1;
				end
				POST_NUM_DSH: begin
					num_q <= {mag[P_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
					neg_q <= lt_t1;
				end
				POST_DEN_P:    den_q <= prod[DEN_W-1:0];
				POST_NUM_PSH: begin
					num_q <= {prod[P_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
					neg_q <= 1'b0;
				end
				POST_CONV_SUM: begin
					num_q <= csum;
					neg_q <= cneg;
				end
				default: ;
			endcase
		end
		if (cmd.num_sl) begin
			num_q <= P_W'(sl_q);
			neg_q <= 1'b0;
		end
		if (cmd.conv_out)
			conv_q <= sat64(cq, covf, neg_q);
		if (cmd.out_ld) begin
			upd_o  <= ~kind_q;
			gain_o <= gain_q;
			off_o  <= off_q;
			conv_o <= kind_q ? conv_q : '0;
		end
	end

	assign sts.mul_done = mul_done;
	assign sts.div_done = div_done;
	assign sts.dz       = dz_q;
	assign m_tdata      = {conv_o, off_o, gain_o};
	assign m_tuser      = upd_o;
endmodule

FILE: src/wcr_ctrl.sv
// ----------------------------------------------------------------------------
// wcr_ctrl
// Sequencer: ring update, product steps, divisions and result hand-off.
// ----------------------------------------------------------------------------
module wcr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          s_tuser,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  wcr_pkg::sts_t sts,
	output wcr_pkg::cmd_t cmd
);
	import wcr_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD    = 4'd1;
	localparam logic [3:0] S_LD    = 4'd2;
	localparam logic [3:0] S_SUMS  = 4'd3;
	localparam logic [3:0] S_MGO   = 4'd4;
	localparam logic [3:0] S_MWAIT = 4'd5;
	localparam logic [3:0] S_NEXT  = 4'd6;
	localparam logic [3:0] S_DGO   = 4'd7;
	localparam logic [3:0] S_DWAIT = 4'd8;
	localparam logic [3:0] S_NUMSL = 4'd9;
	localparam logic [3:0] S_CONV  = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;

	// product steps
	localparam logic [3:0] K_OD_OD   = 4'd0;
	localparam logic [3:0] K_OD_OL   = 4'd1;
	localparam logic [3:0] K_DV_DV   = 4'd2;
	localparam logic [3:0] K_DV_LC   = 4'd3;
	localparam logic [3:0] K_N_SDD   = 4'd4;
	localparam logic [3:0] K_SD_SD   = 4'd5;
	localparam logic [3:0] K_N_SDL   = 4'd6;
	localparam logic [3:0] K_SD_SL   = 4'd7;
	localparam logic [3:0] K_SDD_SL  = 4'd8;
	localparam logic [3:0] K_SD_SDL  = 4'd9;
	localparam logic [3:0] K_C_C     = 4'd10;
	localparam logic [3:0] K_C1_N    = 4'd11;
	localparam logic [3:0] K_SL_C    = 4'd12;
	localparam logic [3:0] K_CONV    = 4'd13;

	logic [3:0] state_q, step_q;
	logic       tgt_gain_q, out_valid_q;
	sel_t       a_sel, b_sel;
	post_t      post;
	logic       accept, out_take;

	assign accept   = s_tvalid && (state_q == S_IDLE);
	assign out_take = (state_q == S_DONE) && (!out_valid_q || m_tready);

	// operands and post step for each product
	always_comb begin
		unique case (step_q)
			K_OD_OD:  begin a_sel = SEL_OD;   b_sel = SEL_OD;  post = POST_SDD_SUB;  end
			K_OD_OL:  begin a_sel = SEL_OD;   b_sel = SEL_OL;  post = POST_SDL_SUB;  end
			K_DV_DV:  begin a_sel = SEL_DEV;  b_sel = SEL_DEV; post = POST_SDD_ADD;  end
			K_DV_LC:  begin a_sel = SEL_DEV;  b_sel = SEL_LOC; post = POST_SDL_ADD;  end
			K_N_SDD:  begin a_sel = SEL_N;    b_sel = SEL_SDD; post = POST_T1;       end
			K_SD_SD:  begin a_sel = SEL_SD;   b_sel = SEL_SD;  post = POST_DEN_DIFF; end
			K_N_SDL:  begin a_sel = SEL_N;    b_sel = SEL_SDL; post = POST_T1;       end
			K_SD_SL:  begin a_sel = SEL_SD;   b_sel = SEL_SL;  post = POST_NUM_DSH;  end
			K_SDD_SL: begin a_sel = SEL_SDD;  b_sel = SEL_SL;  post = POST_T1;       end
			K_SD_SDL: begin a_sel = SEL_SD;   b_sel = SEL_SDL; post = POST_NUM_DIFF; end
			K_C_C:    begin a_sel = SEL_DEV;  b_sel = SEL_DEV; post = POST_T1;       end
			K_C1_N:   begin a_sel = SEL_T1P1; b_sel = SEL_N;   post = POST_DEN_P;    end
			K_SL_C:   begin a_sel = SEL_SL;   b_sel = SEL_DEV; post = POST_NUM_PSH;  end
			K_CONV:   begin a_sel = SEL_DEV;  b_sel = SEL_GM;  post = POST_CONV_SUM; end
			default:  begin a_sel = SEL_N;    b_sel = SEL_N;   post = POST_NONE;     end
		endcase
	end

	// commands
	always_comb begin
		cmd          = '0;
		cmd.a_sel    = a_sel;
		cmd.b_sel    = b_sel;
		cmd.post     = POST_NONE;
		cmd.ld_item  = accept;
		cmd.ram_rd   = (state_q == S_RD);
		cmd.ld_old   = (state_q == S_LD);
		cmd.sums     = (state_q == S_SUMS);
		cmd.mul_go   = (state_q == S_MGO);
		cmd.div_go   = (state_q == S_DGO);
		cmd.num_sl   = (state_q == S_NUMSL);
		cmd.conv_out = (state_q == S_CONV);
		cmd.out_ld   = out_take;
		if (state_q == S_MWAIT && sts.mul_done)
			cmd.post = post;
		if (state_q == S_DWAIT && sts.div_done) begin
			cmd.ld_gain = tgt_gain_q;
			cmd.ld_off  = !tgt_gain_q;
		end
	end

	// sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= K_OD_OD;
			tgt_gain_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_take)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (s_tuser) begin
							step_q  <= K_CONV;
							state_q <= S_MGO;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD:   state_q <= S_LD;
				S_LD:   state_q <= S_SUMS;
				S_SUMS: begin
					step_q  <= K_OD_OD;
					state_q <= S_MGO;
				end
				S_MGO:  state_q <= S_MWAIT;
				S_MWAIT: begin
					if (sts.mul_done)
						state_q <= S_NEXT;
				end
				S_NEXT: begin
					priority if (step_q == K_SD_SD) begin
						step_q  <= sts.dz ? K_C_C : K_N_SDL;
						state_q <= S_MGO;
					end else if (step_q == K_SD_SL || step_q == K_SL_C) begin
						tgt_gain_q <= 1'b1;
						state_q    <= S_DGO;
					end else if (step_q == K_SD_SDL) begin
						tgt_gain_q <= 1'b0;
						state_q    <= S_DGO;
					end else if (step_q == K_CONV) begin
						state_q <= S_CONV;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= S_MGO;
					end
				end
				S_DGO:  state_q <= S_DWAIT;
				S_DWAIT: begin
					if (sts.div_done) begin
						if (!tgt_gain_q)
							state_q <= S_DONE;
						else if (step_q == K_SD_SL) begin
							step_q  <= K_SDD_SL;
							state_q <= S_MGO;
						end else
							state_q <= S_NUMSL;
					end
				end
				S_NUMSL: begin
					tgt_gain_q <= 1'b0;
					state_q    <= S_DGO;
				end
				S_CONV: state_q <= S_DONE;
				S_DONE: begin
					if (out_take)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
endmodule

FILE: src/windowed_clock_regression.sv
// ----------------------------------------------------------------------------
// windowed_clock_regression
// Sliding-window least-squares fit of local time against device time.
// ----------------------------------------------------------------------------
// One item is worked on at a time. An update takes ten wide products and
// two divisions at WINDOW_DEPTH 16, nine products and two divisions when
// every device time in the window is equal, and a conversion one product.
// The products come from the shared multiplier, which forms ND*ND partial
// products of 32x32 bits per product (ND = 4 for depths up to 256), and the
// quotients come from the shared divider.
// The result waits in an output register while the next item is taken in.
// Ring slots read as the pair (1,1) until written; there is no clearing pass.
module windowed_clock_regression #(
	parameter int WINDOW_DEPTH = wcr_pkg::DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// fields from bit 0: device_epoch[31:0], device_ticks[47:32],
	// local_time_ns[110:48], zero pad [111]
	input  logic [wcr_pkg::IN_DATA_W-1:0]   s_tdata,
	// kind: 0 update, 1 convert
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// fields from bit 0: fit_gain[63:0], fit_offset_ns[127:64],
	// converted_time_ns[191:128]
	output logic [wcr_pkg::OUT_DATA_W-1:0]  m_tdata,
	// was_update
	output logic                            m_tuser
);
	import wcr_pkg::*;
	`include "windowed_clock_regression_defines.svh"

	cmd_t cmd;
	sts_t sts;

	wcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wcr_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// checks on sequencing and results
	`WCR_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	`WCR_ASSERT_NEVER(a_units_exclusive, sts.mul_done && sts.div_done)
	`WCR_ASSERT_IMP(a_update_conv_zero, m_tvalid && m_tuser, m_tdata[191:128] == 64'd0)
	`WCR_ASSERT_IMP(a_one_unit_start, cmd.div_go, !cmd.mul_go && !cmd.sums)
endmodule

FILE: sim/windowed_clock_regression_tb.sv
// ----------------------------------------------------------------------------
// windowed_clock_regression_tb
// Drives clock pairs and conversion requests into the regression block and
// checks every result against an in-bench least-squares fit of the window.
// ----------------------------------------------------------------------------
module windowed_clock_regression_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wcr_pkg::*;

	localparam int      DEPTH    = 16;
	localparam logic    KIND_UPD = 1'b0;
	localparam logic    KIND_CNV = 1'b1;
	localparam int      N_RAND   = 1880;
	localparam int      SETTLE   = 400;

	typedef logic [255:0] wide_t;

	typedef struct {
		logic        kind;
		logic [31:0] epoch;
		logic [15:0] ticks;
		logic [62:0] loc;
		logic        typed;
		logic [63:0] gain;
		logic [63:0] offset;
		logic [63:0] conv;
	} row_t;

	typedef struct {
		logic        was_update;
		logic [63:0] gain;
		logic [63:0] offset;
		logic [63:0] conv;
	} fit_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;

	windowed_clock_regression #(.WINDOW_DEPTH(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// window copy held by the fit predictor
	logic [47:0] dev_ring [DEPTH];
	logic [62:0] loc_ring [DEPTH];
	int          slot;
	wide_t       sum_d, sum_l, sum_dd, sum_dl;
	logic [63:0] gain_now, offset_now;

	fit_result_t pending_fits[$];
	int          errors;
	logic        quiet;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#60ms;
		$display("windowed_clock_regression: mismatch");
		$finish;
	end

	function automatic wide_t div_nearest(input wide_t num, input wide_t den);
		wide_t q, r;
		q = num / den;
		r = num % den;
		if ((r << 1) >= den)
			q = q + 1;
		return q;
	endfunction

	function automatic logic [63:0] clamp64(input wide_t mag, input logic neg);
		if (neg) begin
			if (mag >= (wide_t'(1) << 63))
				return {1'b1, 63'd0};
			return -mag[63:0];
		end
		if (mag > {1'b0, {63{1'b1}}})
			return {1'b0, {63{1'b1}}};
		return mag[63:0];
	endfunction

	task automatic clear_window();
		for (int i = 0; i < DEPTH; i++) begin
			dev_ring[i] = 48'd1;
			loc_ring[i] = 63'd1;
		end
		slot       = 0;
		sum_d      = wide_t'(DEPTH);
		sum_l      = wide_t'(DEPTH);
		sum_dd     = wide_t'(DEPTH);
		sum_dl     = wide_t'(DEPTH);
		gain_now   = '0;
		offset_now = '0;
	endtask

	// advance the window by one pair and refit, or map a device time
	function automatic fit_result_t predict_fit(input logic kind, input logic [47:0] dev,
		input logic [62:0] loc);
		fit_result_t res;
		wide_t nn, det, a, b, mag, den, c;
		logic neg, gneg, oneg;
		wide_t gm, om;
		nn = wide_t'(DEPTH);
		res.conv = '0;
		if (kind == KIND_UPD) begin
			slot = (slot + 1) % DEPTH;
			sum_d  = sum_d - dev_ring[slot] + dev;
			sum_l  = sum_l - loc_ring[slot] + loc;
			sum_dd = sum_dd - wide_t'(dev_ring[slot]) * dev_ring[slot] + wide_t'(dev) * dev;
			sum_dl = sum_dl - wide_t'(dev_ring[slot]) * loc_ring[slot] + wide_t'(dev) * loc;
			dev_ring[slot] = dev;
			loc_ring[slot] = loc;
			det = nn * sum_dd - sum_d * sum_d;
			if (det != 0) begin
				a = nn * sum_dl;
				b = sum_d * sum_l;
				neg = a < b;
				mag = neg ? b - a : a - b;
				gain_now = clamp64(div_nearest(mag << 32, det), neg);
				a = sum_dd * sum_l;
				b = sum_d * sum_dl;
				neg = a < b;
				mag = neg ? b - a : a - b;
				offset_now = clamp64(div_nearest(mag, det), neg);
			end else begin
				// all device times equal: minimum-norm fit
				c   = dev_ring[0];
				den = (c * c + 1) * nn;
				gain_now   = clamp64(div_nearest((sum_l * c) << 32, den), 1'b0);
				offset_now = clamp64(div_nearest(sum_l, den), 1'b0);
			end
		end else begin
			gneg = gain_now[63];
			oneg = offset_now[63];
			gm = gneg ? wide_t'(-gain_now) : wide_t'(gain_now);
			om = oneg ? wide_t'(-offset_now) : wide_t'(offset_now);
			gm[255:64] = '0;
			om[255:64] = '0;
			a = wide_t'(dev) * gm;
			b = om << 32;
			if (gneg == oneg) begin
				mag = a + b;
				neg = gneg;
			end else begin
				mag = (a < b) ? b - a : a - b;
				neg = (a < b) ? oneg : gneg;
			end
			res.conv = clamp64(div_nearest(mag, wide_t'(1) << 32), neg);
		end
		res.was_update = (kind == KIND_UPD);
		res.gain       = gain_now;
		res.offset     = offset_now;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("result mismatch on %s: got %h, want %h", what, got, want);
		errors++;
	endtask

	// hand one item to the block and hold it until taken
	task automatic send_item(input row_t r);
		fit_result_t res;
		if (!quiet && $urandom_range(99) < 14) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= r.kind;
		s_tdata  <= {1'b0, r.loc, r.ticks, r.epoch};
		do @(posedge clk); while (!s_tready);
		res = predict_fit(r.kind, {r.epoch, r.ticks}, r.loc);
		if (r.typed) begin
			res.gain   = r.gain;
			res.offset = r.offset;
			res.conv   = r.conv;
		end
		pending_fits.push_back(res);
	endtask

	// receiver stalls
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= quiet || ($urandom_range(99) >= 14);
	end

	// compare every taken result with the oldest expectation
	always @(posedge clk) begin
		fit_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_fits.size() == 0) begin
				$display("result with nothing pending");
				errors++;
			end else begin
				want = pending_fits.pop_front();
				if (m_tuser !== want.was_update)
					report_mismatch("was_update", 64'(m_tuser), 64'(want.was_update));
				if (m_tdata[63:0] !== want.gain)
					report_mismatch("fit_gain", m_tdata[63:0], want.gain);
				if (m_tdata[127:64] !== want.offset)
					report_mismatch("fit_offset_ns", m_tdata[127:64], want.offset);
				if (m_tdata[191:128] !== want.conv)
					report_mismatch("converted_time_ns", m_tdata[191:128], want.conv);
			end
		end
	end

	initial begin
		row_t        rows[$];
		row_t        r;
		logic [47:0] dev_now, step;
		logic [63:0] rate, base, lt;
		int          deadline;
		errors   = 0;
		quiet    = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = 1'b0;
		s_tdata  = '0;
		clear_window();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset fit, minimum-norm fit, extremes, falling and saturating fits
		rows = '{
			'{KIND_CNV, 32'd0, 16'd0, 63'd0, 1'b1, 64'd0, 64'd0, 64'd0},
			'{KIND_CNV, '1, '1, '1, 1'b1, 64'd0, 64'd0, 64'd0},
			'{KIND_UPD, 32'd0, 16'd1, 63'd1, 1'b1, 64'h8000_0000, 64'd1, 64'd0},
			'{KIND_UPD, 32'd0, 16'd1, 63'd1001, 1'b1, 64'd136365211648, 64'd32, 64'd0},
			'{KIND_CNV, 32'd0, 16'd1000, 63'd0, 1'b0, 0, 0, 0},
			'{KIND_UPD, 32'd0, 16'd2, 63'd2000, 1'b0, 0, 0, 0},
			'{KIND_UPD, 32'd0, 16'd3, 63'd3000, 1'b0, 0, 0, 0},
			'{KIND_CNV, '1, '1, 63'd0, 1'b0, 0, 0, 0},
			'{KIND_UPD, '1, '1, '1, 1'b0, 0, 0, 0},
			'{KIND_CNV, '1, '1, 63'd5, 1'b0, 0, 0, 0},
			'{KIND_CNV, 32'd0, 16'd0, 63'd0, 1'b0, 0, 0, 0},
			'{KIND_UPD, 32'd0, 16'd0, 63'd0, 1'b0, 0, 0, 0},
			'{KIND_UPD, 32'd5, 16'd0, '1, 1'b0, 0, 0, 0},
			'{KIND_UPD, 32'd6, 16'd0, 63'd0, 1'b0, 0, 0, 0},
			'{KIND_CNV, 32'd7, 16'h8000, 63'd0, 1'b0, 0, 0, 0},
			'{KIND_CNV, '1, 16'd0, 63'd0, 1'b0, 0, 0, 0},
			'{KIND_UPD, 32'h8000_0000, 16'h5555, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0, 0, 0, 0},
			'{KIND_UPD, 32'h8000_0000, 16'h5556, 63'h1555_5555_5555_5555, 1'b0, 0, 0, 0},
			'{KIND_CNV, 32'h5555_5555, 16'hAAAA, 63'd0, 1'b0, 0, 0, 0},
			'{KIND_CNV, 32'd0, 16'd1, 63'd0, 1'b0, 0, 0, 0}
		};
		foreach (rows[i])
			send_item(rows[i]);

		// random: mostly a drifting clock with jitter, some noise and flat windows
		dev_now = 48'd1000;
		rate    = 64'd1000;
		base    = 64'd12345;
		for (int n = 0; n < N_RAND; n++) begin
			quiet = (n >= 500 && n < 800);
			if (n == 1000) begin
				// hold off until the block has drained
				s_tvalid <= 1'b0;
				while (pending_fits.size() != 0) @(posedge clk);
			end
			if (n % 300 == 0) begin
				rate    = 64'($urandom_range(1, 5000));
				dev_now = {$urandom_range(0, 1000), 16'd0};
				base    = {$urandom, $urandom} >> $urandom_range(1, 40);
			end
			r.typed = 1'b0;
			r.gain = '0;
			r.offset = '0;
			r.conv = '0;
			case ($urandom_range(9))
				0, 1: begin
					// unrelated values over the full field ranges
					r.kind  = 1'($urandom_range(1));
					r.epoch = $urandom;
					r.ticks = 16'($urandom);
					r.loc   = 63'({$urandom, $urandom});
				end
				2: begin
					// repeat the device time to flatten the window
					r.kind  = KIND_UPD;
					{r.epoch, r.ticks} = dev_now;
					r.loc   = 63'({$urandom, $urandom} >> $urandom_range(0, 62));
				end
				3, 4: begin
					r.kind  = KIND_CNV;
					{r.epoch, r.ticks} = dev_now + $urandom_range(0, 100000);
					r.loc   = '0;
				end
				default: begin
					step    = 48'($urandom_range(1, 70000));
					dev_now = dev_now + step;
					lt      = dev_now * rate + base + $urandom_range(0, 2000);
					r.kind  = KIND_UPD;
					{r.epoch, r.ticks} = dev_now;
					r.loc   = lt[62:0];
				end
			endcase
			send_item(r);
		end
		s_tvalid <= 1'b0;
		quiet = 1'b0;

		deadline = 0;
		while (pending_fits.size() != 0 && deadline < 200000) begin
			@(posedge clk);
			deadline++;
		end
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && pending_fits.size() == 0)
			$display("windowed_clock_regression: match");
		else
			$display("windowed_clock_regression: mismatch");
		$finish;
	end

endmodule
